// ===== rtl/core/qpl_pkg.sv =====
// ----------------------------------------------------------------------------
// qpl_pkg
// Shared types and default constants of the QRS main peak locator.
// ----------------------------------------------------------------------------
package qpl_pkg;

  localparam int unsigned BufDepthDef   = 1024;
  localparam int unsigned CenterBackDef = 25;
  localparam int unsigned LeadDef       = 29;
  localparam int unsigned HalfSpanDef   = 36;
  localparam int unsigned SlopeGapDef   = 7;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DelayW  = 9;
  localparam int unsigned CountW  = 32;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_LOCATE = 1'b1
  } qpl_op_e;

  typedef struct packed {
    logic              start;
    logic [DelayW-1:0] delay;
  } qpl_req_t;

  typedef struct packed {
    logic [CountW-1:0] location;
    logic              is_max;
  } qpl_res_t;

endpackage

// ===== rtl/core/qpl_sample_ram.sv =====
// ----------------------------------------------------------------------------
// qpl_sample_ram
// Circular sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qpl_sample_ram import qpl_pkg::*; #(
  parameter int unsigned DEPTH = BufDepthDef,
  parameter int unsigned AW    = $clog2(BufDepthDef)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [SampleW-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [SampleW-1:0] rd_data_o
);

  logic [SampleW-1:0] mem [DEPTH];
  logic [SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/qpl_engine.sv =====
// ----------------------------------------------------------------------------
// qpl_engine
// Locate sequencer: scans the store window for the first maximum and minimum,
// reads their neighbors, evaluates slopes and picks the main wave.
// ----------------------------------------------------------------------------
module qpl_engine import qpl_pkg::*; #(
  parameter int unsigned BUF_DEPTH   = BufDepthDef,
  parameter int unsigned CENTER_BACK = CenterBackDef,
  parameter int unsigned LEAD        = LeadDef,
  parameter int unsigned HALF_SPAN   = HalfSpanDef,
  parameter int unsigned SLOPE_GAP   = SlopeGapDef,
  parameter int unsigned AW          = $clog2(BufDepthDef)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qpl_req_t           req_i,
  input  logic [AW-1:0]      wp_i,
  input  logic [CountW-1:0]  count_i,
  output logic               idle_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [SampleW-1:0] rd_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output qpl_res_t           res_o
);

  localparam int unsigned NScan  = 2 * HALF_SPAN + 1;
  localparam int unsigned CntW   = $clog2(NScan + 1);
  localparam int unsigned BackK  = (CENTER_BACK + LEAD) % BUF_DEPTH;
  localparam int unsigned DW     = (AW + 1 > DelayW) ? AW + 1 : DelayW;
  localparam int unsigned DiffW  = SampleW + 1;
  localparam int unsigned SumW   = SampleW + 2;

  localparam logic [1:0] NbLeft  = 2'd0;
  localparam logic [1:0] NbRight = 2'd1;
  localparam logic [1:0] NbFar   = 2'd2;
  localparam logic [1:0] NbNear  = 2'd3;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_BACK   = 10'b0000000010,
    ST_SCAN   = 10'b0000000100,
    ST_DRAIN  = 10'b0000001000,
    ST_NEIGH  = 10'b0000010000,
    ST_SETTLE = 10'b0000100000,
    ST_EVAL   = 10'b0001000000,
    ST_PICK   = 10'b0010000000,
    ST_LOC    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } qpl_state_e;

  function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] p,
                                              input logic [AW-1:0] d);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(BUF_DEPTH) - {1'b0, d};
    return (s >= (AW+1)'(BUF_DEPTH)) ? AW'(s - (AW+1)'(BUF_DEPTH)) : AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_fwd(input logic [AW-1:0] p,
                                             input logic [AW-1:0] d);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, d};
    return (s >= (AW+1)'(BUF_DEPTH)) ? AW'(s - (AW+1)'(BUF_DEPTH)) : AW'(s);
  endfunction

  function automatic logic is_turn(input logic signed [DiffW-1:0] ls,
                                   input logic signed [DiffW-1:0] rs);
    return (ls == '0) || (rs == '0) || (ls[DiffW-1] != rs[DiffW-1]);
  endfunction

  function automatic logic [DiffW-1:0] abs_diff(input logic signed [DiffW-1:0] v);
    return v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

  qpl_state_e state_q, state_d;
  logic              back_q, back_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        jcnt_q, jcnt_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     dmod_q;

  logic              scan_vld_q, first_q;
  logic [AW-1:0]     tag_q;
  logic signed [SampleW-1:0] vmax_q, vmin_q;
  logic [AW-1:0]     pmax_q, pmin_q;

  logic              nb_vld_q;
  logic [2:0]        nb_tag_q;
  logic signed [SampleW-1:0] nb_q [8];

  logic              tmax_q, tmin_q;
  logic [SumW-1:0]   smax_q, smin_q;
  logic              pick_q;
  logic [AW-1:0]     shift_q;
  logic [CountW-1:0] loc_q;

  logic [DW-1:0]     delay_ext;
  logic [AW-1:0]     dmod;
  logic [AW-1:0]     nb_base, nb_addr;
  logic signed [SampleW-1:0] rd_val;

  logic signed [DiffW-1:0] mx_ls, mx_rs, mx_fl, mx_fr;
  logic signed [DiffW-1:0] mn_ls, mn_rs, mn_fl, mn_fr;
  logic [SumW+2:0]   wmax, wmin;
  logic              pick;

  assign rd_val    = $signed(rd_data_i);
  assign delay_ext = DW'(req_i.delay);
  assign dmod      = (delay_ext >= DW'(BUF_DEPTH)) ? AW'(delay_ext - DW'(BUF_DEPTH))
                                                    : AW'(delay_ext);

  always_comb begin
    nb_base = jcnt_q[2] ? pmin_q : pmax_q;
    case (jcnt_q[1:0])
      NbLeft:  nb_addr = wrap_back(nb_base, AW'(1));
      NbRight: nb_addr = wrap_fwd(nb_base, AW'(1));
      NbFar:   nb_addr = wrap_back(nb_base, AW'(SLOPE_GAP));
      NbNear:  nb_addr = wrap_fwd(nb_base, AW'(SLOPE_GAP));
      default: nb_addr = nb_base;
    endcase
  end

  // slope terms around the maximum and minimum
  assign mx_ls = DiffW'(vmax_q) - DiffW'(nb_q[0]);
  assign mx_rs = DiffW'(nb_q[1]) - DiffW'(vmax_q);
  assign mx_fl = DiffW'(vmax_q) - DiffW'(nb_q[2]);
  assign mx_fr = DiffW'(nb_q[3]) - DiffW'(vmax_q);
  assign mn_ls = DiffW'(vmin_q) - DiffW'(nb_q[4]);
  assign mn_rs = DiffW'(nb_q[5]) - DiffW'(vmin_q);
  assign mn_fl = DiffW'(vmin_q) - DiffW'(nb_q[6]);
  assign mn_fr = DiffW'(nb_q[7]) - DiffW'(vmin_q);

  // 5*maxsum against 4*minsum
  assign wmax = (SumW+3)'({smax_q, 2'b00}) + (SumW+3)'(smax_q);
  assign wmin = (SumW+3)'({smin_q, 2'b00});
  assign pick = (tmax_q == tmin_q) ? (!tmax_q || (wmax >= wmin)) : tmax_q;

  always_comb begin
    state_d   = state_q;
    back_d    = back_q;
    cnt_d     = cnt_q;
    jcnt_d    = jcnt_q;
    pos_d     = pos_q;
    rd_en_o   = 1'b0;
    rd_addr_o = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          state_d = ST_BACK;
          back_d  = 1'b0;
        end
      end
      ST_BACK: begin
        if (!back_q) begin
          pos_d  = wrap_back(wp_i, dmod_q);
          back_d = 1'b1;
        end else begin
          pos_d   = wrap_back(pos_q, AW'(BackK));
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en_o = 1'b1;
        pos_d   = wrap_fwd(pos_q, AW'(1));
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(NScan - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        jcnt_d  = '0;
        state_d = ST_NEIGH;
      end
      ST_NEIGH: begin
        rd_en_o   = 1'b1;
        rd_addr_o = nb_addr;
        jcnt_d    = jcnt_q + 1'b1;
        if (jcnt_q == 3'd7) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_PICK;
      ST_PICK:   state_d = ST_LOC;
      ST_LOC:    state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      back_q     <= 1'b0;
      cnt_q      <= '0;
      jcnt_q     <= '0;
      scan_vld_q <= 1'b0;
      nb_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      back_q     <= back_d;
      cnt_q      <= cnt_d;
      jcnt_q     <= jcnt_d;
      scan_vld_q <= (state_q == ST_SCAN);
      nb_vld_q   <= (state_q == ST_NEIGH);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    tag_q    <= pos_q;
    first_q  <= (state_q == ST_SCAN) && (cnt_q == '0);
    nb_tag_q <= jcnt_q;
    if (state_q == ST_IDLE && req_i.start) begin
      dmod_q <= dmod;
    end
    if (scan_vld_q) begin
      if (first_q || rd_val > vmax_q) begin
        vmax_q <= rd_val;
        pmax_q <= tag_q;
      end
      if (first_q || rd_val < vmin_q) begin
        vmin_q <= rd_val;
        pmin_q <= tag_q;
      end
    end
    if (nb_vld_q) begin
      nb_q[nb_tag_q] <= rd_val;
    end
    if (state_q == ST_EVAL) begin
      tmax_q <= is_turn(mx_ls, mx_rs);
      tmin_q <= is_turn(mn_ls, mn_rs);
      smax_q <= SumW'(abs_diff(mx_fl)) + SumW'(abs_diff(mx_fr));
      smin_q <= SumW'(abs_diff(mn_fl)) + SumW'(abs_diff(mn_fr));
    end
    if (state_q == ST_PICK) begin
      pick_q  <= pick;
      shift_q <= wrap_back(wp_i, pick ? pmax_q : pmin_q);
    end
    if (state_q == ST_LOC) begin
      loc_q <= count_i - CountW'(shift_q) + CountW'(1);
    end
  end

  assign idle_o         = (state_q == ST_IDLE);
  assign res_valid_o    = (state_q == ST_DONE);
  assign res_o.location = loc_q;
  assign res_o.is_max   = pick_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == ST_IDLE)
    else $error("locate request while engine busy");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !res_ready_i |=> (state_q == ST_DONE) && $stable(res_o))
    else $error("pending result dropped or changed");

  a_scan_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_vld_q |-> $past(rd_en_o) && $past(state_q == ST_SCAN))
    else $error("scan data without a scan read");

  a_neigh_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETTLE) |-> $past(jcnt_q == 3'd7) && nb_vld_q)
    else $error("neighbor read sequence incomplete");

endmodule

// ===== rtl/core/qrs_main_peak_locator_top.sv =====
// ----------------------------------------------------------------------------
// qrs_main_peak_locator_top
// Push requests store ECG samples in a circular store; locate requests return
// the sample number of the main wave of the QRS complex.
// ----------------------------------------------------------------------------
// Push: accepted whenever no locate runs; pushes can follow back to back.
// Locate: the engine makes one store read per cycle, 2*HALF_SPAN+1 scan reads
// and then 8 neighbor reads, before the result is formed.
// No new request is taken while a locate runs; a finished result waits in the
// output register while pushes and the next locate are taken.
// Reset: write pointer to BUF_DEPTH-1, count to zero; store contents undefined.
// ----------------------------------------------------------------------------
module qrs_main_peak_locator_top import qpl_pkg::*; #(
  parameter int unsigned BUF_DEPTH   = BufDepthDef,
  parameter int unsigned CENTER_BACK = CenterBackDef,
  parameter int unsigned LEAD        = LeadDef,
  parameter int unsigned HALF_SPAN   = HalfSpanDef,
  parameter int unsigned SLOPE_GAP   = SlopeGapDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [DelayW-1:0]  detect_delay_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CountW-1:0]  qrs_location_o,
  output logic               peak_is_maximum_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic [AW-1:0]     wp_q, wp_d, wp_fwd;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  qpl_res_t          out_q;

  logic              in_acc, push_acc;
  logic              eng_idle;
  qpl_req_t          req;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [SampleW-1:0] rd_data;
  logic              res_valid, res_take;
  qpl_res_t          res;

  assign in_ready_o = eng_idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign push_acc   = in_acc && (qpl_op_e'(opcode_i) == OP_PUSH);
  assign req.start  = in_acc && (qpl_op_e'(opcode_i) == OP_LOCATE);
  assign req.delay  = detect_delay_i;

  assign wp_fwd  = (wp_q == AW'(BUF_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign wp_d    = push_acc ? wp_fwd : wp_q;
  assign count_d = push_acc ? count_q + 1'b1 : count_q;

  assign res_take    = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= AW'(BUF_DEPTH - 1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  qpl_sample_ram #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push_acc),
    .wr_addr_i (wp_fwd),
    .wr_data_i (sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  qpl_engine #(
    .BUF_DEPTH   (BUF_DEPTH),
    .CENTER_BACK (CENTER_BACK),
    .LEAD        (LEAD),
    .HALF_SPAN   (HALF_SPAN),
    .SLOPE_GAP   (SLOPE_GAP),
    .AW          (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .wp_i        (wp_q),
    .count_i     (count_q),
    .idle_o      (eng_idle),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res)
  );

  assign out_valid_o       = out_valid_q;
  assign qrs_location_o    = out_q.location;
  assign peak_is_maximum_o = out_q.is_max;

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_acc |=> count_q == $past(count_q) + 1'b1)
    else $error("push not counted");

  a_wp_stable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(wp_q) && $stable(count_q))
    else $error("store pointer moved during locate");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_acc |=> wp_q <= AW'(BUF_DEPTH - 1))
    else $error("write pointer out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule
